FILE: rtl/ikc_pkg.sv
`timescale 1ns / 1ps

package ikc_pkg;

  // default position widths
  localparam int LINE_BITS_DEFAULT   = 16;
  localparam int COLUMN_BITS_DEFAULT = 16;

  // field widths
  localparam int POS_W   = 16;
  localparam int INDEX_W = 5;
  localparam int FIXED_W = 18;
  localparam int COUNT_W = 3;

  // word buffer
  localparam int HEAD_DEPTH = 5;
  localparam int COUNT_MAX  = 6;
  localparam int NUM_WORDS  = 16;

  // word indexes with special meaning
  localparam logic [INDEX_W-1:0] W_MOD   = 5'd4;
  localparam logic [INDEX_W-1:0] W_TRUE  = 5'd12;
  localparam logic [INDEX_W-1:0] W_FALSE = 5'd13;
  localparam logic [INDEX_W-1:0] W_PI    = 5'd14;
  localparam logic [INDEX_W-1:0] W_E     = 5'd15;
  localparam logic [INDEX_W-1:0] NO_WORD = 5'd16;

  // q2.16: 3.14159 and 2.71828 scaled by 65536, rounded to nearest
  localparam logic [FIXED_W-1:0] FIXED_PI = 18'd205887;
  localparam logic [FIXED_W-1:0] FIXED_E  = 18'd178145;

  // character class bounds
  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_UNDER    = 8'd95;
  localparam logic [7:0] CH_NUL      = 8'd0;

  // fixed word list, first character at index 0
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][HEAD_DEPTH] = '{
    '{"v", "a", "r", CH_NUL, CH_NUL},
    '{"a", "n", "d", CH_NUL, CH_NUL},
    '{"o", "r", CH_NUL, CH_NUL, CH_NUL},
    '{"x", "o", "r", CH_NUL, CH_NUL},
    '{"m", "o", "d", CH_NUL, CH_NUL},
    '{"i", "f", CH_NUL, CH_NUL, CH_NUL},
    '{"t", "h", "e", "n", CH_NUL},
    '{"e", "l", "i", "f", CH_NUL},
    '{"e", "l", "s", "e", CH_NUL},
    '{"w", "h", "i", "l", "e"},
    '{"d", "o", CH_NUL, CH_NUL, CH_NUL},
    '{"f", "u", "n", "c", CH_NUL},
    '{"t", "r", "u", "e", CH_NUL},
    '{"f", "a", "l", "s", "e"},
    '{"p", "i", CH_NUL, CH_NUL, CH_NUL},
    '{"e", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [COUNT_W-1:0] WORD_LEN [NUM_WORDS] = '{
    3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd4, 3'd4,
    3'd4, 3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd1
  };

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_MOD     = 3'd1,
    KIND_INT     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_IDENT   = 3'd4
  } token_kind_e;

  typedef struct packed {
    logic [7:0]       ch;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
  } in_item_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [INDEX_W-1:0] word_index;
    logic               int_value;
    logic [FIXED_W-1:0] fixed_value;
    logic [POS_W-1:0]   token_line;
    logic [POS_W-1:0]   start_col;
    logic [POS_W-1:0]   end_col;
  } token_t;

  // word buffer contents handed to the matcher
  typedef struct packed {
    logic [COUNT_W-1:0]             count;
    logic [HEAD_DEPTH-1:0][7:0]     head;
  } word_t;

  // classification of one word
  typedef struct packed {
    token_kind_e        kind;
    logic [INDEX_W-1:0] index;
    logic               int_value;
    logic [FIXED_W-1:0] fixed_value;
  } match_t;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
           (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
           (c == CH_UNDER);
  endfunction

endpackage

FILE: rtl/ikc_chan_if.sv
`timescale 1ns / 1ps

interface ikc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/ikc_word_track.sv
`timescale 1ns / 1ps

module ikc_word_track #(
  parameter int COLUMN_BITS = ikc_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               ch_i,
  input  logic [ikc_pkg::POS_W-1:0] column_i,
  output logic                     in_word_o,
  output ikc_pkg::word_t           word_o,
  output logic [ikc_pkg::POS_W-1:0] start_o
);
  import ikc_pkg::*;

  localparam int COL_KEEP = (COLUMN_BITS < POS_W) ? COLUMN_BITS : POS_W;

  logic                       in_word_q, in_word_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic [HEAD_DEPTH-1:0][7:0] head_q;
  logic [COL_KEEP-1:0]        start_q;
  logic                       is_w;
  logic [COUNT_W-1:0]         base;

  assign is_w = is_word_char(ch_i);
  // a new word restarts the count at zero
  assign base = in_word_q ? count_q : '0;

  always_comb begin
    in_word_d = in_word_q;
    count_d   = count_q;
    if (step_i) begin
      if (is_w) begin
        in_word_d = 1'b1;
        count_d   = (base < COUNT_W'(COUNT_MAX)) ? base + 1'b1 : base;
      end else if (in_word_q) begin
        in_word_d = 1'b0;
        count_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      count_q   <= '0;
    end else begin
      in_word_q <= in_word_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && is_w && base < COUNT_W'(HEAD_DEPTH)) begin
      head_q[base] <= ch_i;
    end
    if (step_i && is_w && !in_word_q) begin
      start_q <= column_i[COL_KEEP-1:0];
    end
  end

  assign in_word_o    = in_word_q;
  assign word_o.count = count_q;
  assign word_o.head  = head_q;
  assign start_o      = POS_W'(start_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(COUNT_MAX))
    else $error("word length count beyond saturation");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_word_q |-> count_q == '0)
    else $error("count left over outside a word");

  a_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word_q |-> count_q != '0)
    else $error("open word with no characters");

endmodule

FILE: rtl/ikc_match.sv
`timescale 1ns / 1ps

module ikc_match (
  input  ikc_pkg::word_t  word_i,
  output ikc_pkg::match_t match_o
);
  import ikc_pkg::*;

  logic [NUM_WORDS-1:0] hit;
  logic [INDEX_W-1:0]   idx;

  // compare against every fixed word in parallel
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      hit[w] = (word_i.count == WORD_LEN[w]);
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        if (COUNT_W'(i) < WORD_LEN[w] && word_i.head[i] != WORD_TEXT[w][i]) begin
          hit[w] = 1'b0;
        end
      end
    end
  end

  // words are distinct, so at most one hit
  always_comb begin
    idx = NO_WORD;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        idx = INDEX_W'(w);
      end
    end
  end

  always_comb begin
    match_o.index       = idx;
    match_o.int_value   = 1'b0;
    match_o.fixed_value = '0;
    unique case (idx)
      NO_WORD:         match_o.kind = KIND_IDENT;
      W_MOD:           match_o.kind = KIND_MOD;
      W_TRUE: begin
        match_o.kind      = KIND_INT;
        match_o.int_value = 1'b1;
      end
      W_FALSE:         match_o.kind = KIND_INT;
      W_PI: begin
        match_o.kind        = KIND_FLOAT;
        match_o.fixed_value = FIXED_PI;
      end
      W_E: begin
        match_o.kind        = KIND_FLOAT;
        match_o.fixed_value = FIXED_E;
      end
      default:         match_o.kind = KIND_KEYWORD;
    endcase
  end

endmodule

FILE: rtl/identifier_keyword_classifier_unit.sv
`timescale 1ns / 1ps

// channel  dir  modport  payload            one request is
// in_i     in   sink     ch, line, column   one text character
// tok_o    out  source   token fields       one classified word
//
// one character per cycle unless a token is blocked; the character that ends a word
// goes through the input register, and its token is then held in the result register
// rst_ni clears the word tracker's open flag and count and both valid flags at once
// the input register holds only while a word-ending character waits for
// a full result register; every other character passes straight through
// characters inside a word and stray separators produce no token

module identifier_keyword_classifier_unit #(
  parameter int LINE_BITS   = ikc_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = ikc_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ikc_chan_if.sink   in_i,
  ikc_chan_if.source tok_o
);
  import ikc_pkg::*;

  // only the low position bits are kept, and never more than the field
  localparam int LINE_KEEP = (LINE_BITS < POS_W) ? LINE_BITS : POS_W;
  localparam int COL_KEEP  = (COLUMN_BITS < POS_W) ? COLUMN_BITS : POS_W;

  // input stage
  logic     in_valid_q;
  in_item_t in_q;

  // result stage
  logic     tok_valid_q, tok_valid_d;
  token_t   tok_q;

  logic             in_word;
  word_t            word;
  match_t           match;
  logic [POS_W-1:0] word_start;
  logic             emit;
  logic             out_free;
  logic             s1_fire;

  // a non-word character that closes an open word makes a token
  assign emit     = in_valid_q && in_word && !is_word_char(in_q.ch);
  assign out_free = !tok_valid_q || tok_o.ready;
  // the stage only waits when it has a token and nowhere to put it
  assign s1_fire  = in_valid_q && (!emit || out_free);

  assign in_i.ready = !in_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.payload;
    end
  end

  // word buffer: open flag, count, first characters, start column
  ikc_word_track #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .ch_i     (in_q.ch),
    .column_i (in_q.column),
    .in_word_o(in_word),
    .word_o   (word),
    .start_o  (word_start)
  );

  // compare the buffered word against the fixed list
  ikc_match u_match (
    .word_i (word),
    .match_o(match)
  );

  always_comb begin
    tok_valid_d = tok_valid_q;
    if (emit && s1_fire) begin
      tok_valid_d = 1'b1;
    end else if (tok_o.ready) begin
      tok_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && s1_fire) begin
      tok_q.token_kind  <= match.kind;
      tok_q.word_index  <= match.index;
      tok_q.int_value   <= match.int_value;
      tok_q.fixed_value <= match.fixed_value;
      tok_q.token_line  <= POS_W'(in_q.line[LINE_KEEP-1:0]);
      tok_q.start_col   <= word_start;
      tok_q.end_col     <= POS_W'(in_q.column[COL_KEEP-1:0]);
    end
  end

  assign tok_o.valid   = tok_valid_q;
  assign tok_o.payload = tok_q;

  // a token only appears after a word-ending character was consumed
  a_tok_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tok_valid_q) |-> $past(emit && s1_fire))
    else $error("token raised without a closing character");

  // the input stage never stalls for any reason but a blocked token
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !s1_fire |-> emit && tok_valid_q && !tok_o.ready)
    else $error("input stage stalled without a blocked token");

  // identifiers and only identifiers carry the no-match index
  a_ident_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_q |-> ((tok_q.token_kind == KIND_IDENT) == (tok_q.word_index == NO_WORD)))
    else $error("identifier kind and word index disagree");

  // only the word true carries an integer value of one
  a_int_true: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_q && tok_q.int_value |-> tok_q.word_index == W_TRUE)
    else $error("integer value set on a word other than true");

endmodule

FILE: tb/tb_identifier_keyword_classifier_unit.sv
`timescale 1ns / 1ps

module tb_identifier_keyword_classifier_unit;
  import ikc_pkg::*;

  // one directed stimulus line: the character request, plus a hand-written
  // token where the answer is plain to see
  typedef struct packed {
    in_item_t item;
    logic     has_tok;
    token_t   tok;
  } dir_row_t;

  // ways to bend a fixed word into a near miss
  typedef enum logic [1:0] {
    MUT_CASE,
    MUT_SWAP,
    MUT_GROW,
    MUT_TRIM
  } mutation_e;

  localparam token_t NO_TOK           = '0;
  localparam int     NUM_DIRECTED     = 25;
  localparam int     RANDOM_PER_PHASE = 185;
  localparam int     NUM_PHASES       = 3;

  // column of each character equals its row number, except the mod terminator
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // stray separator right after reset
    '{'{8'h20, 16'd0, 16'd0}, 1'b0, NO_TOK},
    // "e" closed by a nul byte
    '{'{"e", 16'd0, 16'd1}, 1'b0, NO_TOK},
    '{'{CH_NUL, 16'd0, 16'd2}, 1'b1,
      '{KIND_FLOAT, W_E, 1'b0, FIXED_E, 16'd0, 16'd1, 16'd2}},
    // "mod" closed by 0xff at the top line and column
    '{'{"m", 16'd0, 16'd3}, 1'b0, NO_TOK},
    '{'{"o", 16'd0, 16'd4}, 1'b0, NO_TOK},
    '{'{"d", 16'd0, 16'd5}, 1'b0, NO_TOK},
    '{'{8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{KIND_MOD, W_MOD, 1'b0, '0, 16'hFFFF, 16'd3, 16'hFFFF}},
    // "true" carries an integer value of one
    '{'{"t", 16'd0, 16'd7}, 1'b0, NO_TOK},
    '{'{"r", 16'd0, 16'd8}, 1'b0, NO_TOK},
    '{'{"u", 16'd0, 16'd9}, 1'b0, NO_TOK},
    '{'{"e", 16'd0, 16'd10}, 1'b0, NO_TOK},
    '{'{8'h20, 16'd7, 16'd11}, 1'b1,
      '{KIND_INT, W_TRUE, 1'b1, '0, 16'd7, 16'd7, 16'd11}},
    // matching is case sensitive: "Do" is no keyword
    '{'{"D", 16'd2, 16'd12}, 1'b0, NO_TOK},
    '{'{"o", 16'd2, 16'd13}, 1'b0, NO_TOK},
    '{'{",", 16'd2, 16'd14}, 1'b1,
      '{KIND_IDENT, NO_WORD, 1'b0, '0, 16'd2, 16'd12, 16'd14}},
    // plain keyword "do", closed by a newline
    '{'{"d", 16'd2, 16'd15}, 1'b0, NO_TOK},
    '{'{"o", 16'd2, 16'd16}, 1'b0, NO_TOK},
    '{'{8'h0A, 16'd2, 16'd17}, 1'b0, NO_TOK},
    // six characters, class edges of every kind, always an identifier
    '{'{"_", 16'd3, 16'd18}, 1'b0, NO_TOK},
    '{'{"z", 16'd3, 16'd19}, 1'b0, NO_TOK},
    '{'{"Z", 16'd3, 16'd20}, 1'b0, NO_TOK},
    '{'{"0", 16'd3, 16'd21}, 1'b0, NO_TOK},
    '{'{"9", 16'd3, 16'd22}, 1'b0, NO_TOK},
    '{'{"x", 16'd3, 16'd23}, 1'b0, NO_TOK},
    '{'{".", 16'd3, 16'd24}, 1'b1,
      '{KIND_IDENT, NO_WORD, 1'b0, '0, 16'd3, 16'd18, 16'd24}}
  };

  // the sixteen fixed words, in word index order
  string fixed_words [NUM_WORDS] = '{
    "var", "and", "or", "xor", "mod", "if", "then", "elif",
    "else", "while", "do", "func", "true", "false", "pi", "e"
  };

  // idle percentages per phase: sender first, then receiver
  int send_idle_by_phase [NUM_PHASES] = '{6, 71, 0};
  int recv_idle_by_phase [NUM_PHASES] = '{71, 6, 0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;

  // tokens still owed by the block, oldest first
  token_t pending_tokens [$];

  // word tracker mirrored from the block's behavior
  logic               word_open;
  logic [COUNT_W-1:0] word_len_seen;
  logic [7:0]         word_head [HEAD_DEPTH];
  logic [POS_W-1:0]   word_col;

  // characters of the next random word
  logic [7:0] word_buf [$];

  always #1 clk_i = ~clk_i;

  ikc_chan_if #(.T(in_item_t)) in_if ();
  ikc_chan_if #(.T(token_t))   tok_if ();

  identifier_keyword_classifier_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .tok_o  (tok_if)
  );

  // digits, both letter cases and the underscore
  function automatic logic is_ident_char(input logic [7:0] c);
    return (c inside {["0":"9"], ["A":"Z"], ["a":"z"], "_"});
  endfunction

  function automatic logic [7:0] rand_ident_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (!is_ident_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_sep_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_ident_char(c));
    return c;
  endfunction

  // advances the mirrored tracker by one character; returns 1 when the
  // character closes a word, with the token it should produce
  function automatic logic predict_token(input in_item_t c, output token_t tok);
    logic [INDEX_W-1:0] idx;
    logic               same;
    tok = '0;
    if (is_ident_char(c.ch)) begin
      if (!word_open) begin
        word_open     = 1'b1;
        word_len_seen = '0;
        word_col      = c.column;
      end
      // only the head of the word is kept, the count stops at six
      if (word_len_seen < HEAD_DEPTH) word_head[word_len_seen] = c.ch;
      if (word_len_seen < COUNT_MAX) word_len_seen = word_len_seen + 1'b1;
      return 1'b0;
    end
    // separator outside a word: nothing happens
    if (!word_open) return 1'b0;

    idx = NO_WORD;
    for (int w = 0; w < NUM_WORDS; w++) begin
      same = (fixed_words[w].len() == int'(word_len_seen));
      for (int i = 0; i < fixed_words[w].len() && same; i++)
        if (fixed_words[w][i] != word_head[i]) same = 1'b0;
      if (same && idx == NO_WORD) idx = INDEX_W'(w);
    end

    tok.word_index = idx;
    if (idx == NO_WORD) begin
      tok.token_kind = KIND_IDENT;
    end else if (idx == W_MOD) begin
      tok.token_kind = KIND_MOD;
    end else if (idx == W_TRUE || idx == W_FALSE) begin
      tok.token_kind = KIND_INT;
      tok.int_value  = (idx == W_TRUE);
    end else if (idx == W_PI || idx == W_E) begin
      tok.token_kind  = KIND_FLOAT;
      tok.fixed_value = (idx == W_PI) ? FIXED_PI : FIXED_E;
    end else begin
      tok.token_kind = KIND_KEYWORD;
    end
    tok.token_line = c.line;
    tok.start_col  = word_col;
    tok.end_col    = c.column;

    word_open     = 1'b0;
    word_len_seen = '0;
    return 1'b1;
  endfunction

  // offers one character, waits for its handshake, then books the token
  // it causes; a typed token overrides the mirrored one
  task automatic push_char(input in_item_t it, input logic use_typed,
                           input token_t typed_tok);
    token_t tok;
    logic   made;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    made = predict_token(it, tok);
    if (use_typed) pending_tokens.push_back(typed_tok);
    else if (made) pending_tokens.push_back(tok);
  endtask

  // mostly real words and near misses, some free-form runs, a few long ones
  task automatic build_word();
    int    pick;
    int    pos;
    int    len;
    string s;
    word_buf.delete();
    pick = $urandom_range(99);
    if (pick < 60) begin
      s = fixed_words[$urandom_range(NUM_WORDS - 1)];
      for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
      if (pick >= 40) begin
        pos = $urandom_range(word_buf.size() - 1);
        case (mutation_e'($urandom_range(3)))
          MUT_CASE: if (word_buf[pos] inside {["a":"z"]}) word_buf[pos] = word_buf[pos] - 8'd32;
          MUT_SWAP: word_buf[pos] = rand_ident_char();
          MUT_GROW: word_buf.push_back(rand_ident_char());
          default:  if (word_buf.size() > 1) void'(word_buf.pop_back());
        endcase
      end
    end else begin
      len = (pick < 85) ? $urandom_range(5, 1) : $urandom_range(12, 6);
      repeat (len) word_buf.push_back(rand_ident_char());
    end
  endtask

  // one word with its terminator, now and then wrapped in noise; only the
  // word and its terminator count toward the phase total
  task automatic send_run(inout int counted);
    in_item_t it;
    if ($urandom_range(9) == 0) begin
      // raw bytes of any class, may open words of their own
      repeat ($urandom_range(4, 1)) begin
        it = '{8'($urandom_range(255)), 16'($urandom), 16'($urandom)};
        push_char(it, 1'b0, NO_TOK);
      end
    end
    build_word();
    foreach (word_buf[i]) begin
      it = '{word_buf[i], 16'($urandom), 16'($urandom)};
      push_char(it, 1'b0, NO_TOK);
    end
    it = '{rand_sep_char(), 16'($urandom), 16'($urandom)};
    push_char(it, 1'b0, NO_TOK);
    counted += word_buf.size() + 1;
    // trailing stray separators
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        it = '{rand_sep_char(), 16'($urandom), 16'($urandom)};
        push_char(it, 1'b0, NO_TOK);
      end
    end
  endtask

  // sender holds off until every booked token has come out
  task automatic drain_tokens();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    if (pending_tokens.size() == 0) begin
      $error("token with none expected: kind %0d, index %0d, end_col %0d",
             got.token_kind, got.word_index, got.end_col);
      fail_count++;
      return;
    end
    want = pending_tokens.pop_front();
    if (got.token_kind !== want.token_kind) begin
      $error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
      fail_count++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
      fail_count++;
    end
    if (got.int_value !== want.int_value) begin
      $error("int_value: expected %0d, actual %0d", want.int_value, got.int_value);
      fail_count++;
    end
    if (got.fixed_value !== want.fixed_value) begin
      $error("fixed_value: expected %0d, actual %0d", want.fixed_value, got.fixed_value);
      fail_count++;
    end
    if (got.token_line !== want.token_line) begin
      $error("token_line: expected %0d, actual %0d", want.token_line, got.token_line);
      fail_count++;
    end
    if (got.start_col !== want.start_col) begin
      $error("start_col: expected %0d, actual %0d", want.start_col, got.start_col);
      fail_count++;
    end
    if (got.end_col !== want.end_col) begin
      $error("end_col: expected %0d, actual %0d", want.end_col, got.end_col);
      fail_count++;
    end
  endtask

  // token side: sample the handshake as it stood before the edge, then
  // pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && tok_if.valid && tok_if.ready) check_token(tok_if.payload);
    tok_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int counted;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    tok_if.ready  = 1'b0;
    word_open     = 1'b0;
    word_len_seen = '0;
    word_col      = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      recv_idle_pct = recv_idle_by_phase[ph];
      if (ph == 0) begin
        foreach (DIRECTED[r])
          push_char(DIRECTED[r].item, DIRECTED[r].has_tok, DIRECTED[r].tok);
      end
      counted = 0;
      while (counted < RANDOM_PER_PHASE) send_run(counted);
      drain_tokens();
    end

    // a few more edges to catch any token the block should not have made
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ikc_pkg.sv
rtl/ikc_chan_if.sv
rtl/ikc_word_track.sv
rtl/ikc_match.sv
rtl/identifier_keyword_classifier_unit.sv
tb/tb_identifier_keyword_classifier_unit.sv
